/* hw/rtl/sample_without_replacement_unit_assert.svh */
// Assertion macros for the distinct-value sampler checker.
// Used by swr_checker; expects signals clk and rst_n in the using scope.
`ifndef SAMPLE_WITHOUT_REPLACEMENT_UNIT_ASSERT_SVH
`define SAMPLE_WITHOUT_REPLACEMENT_UNIT_ASSERT_SVH

// clocked check, off while reset is asserted
`define SWR_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds during reset
`define SWR_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/swr_pkg.sv */
// Package for the distinct-value sampler: widths, register indexes, sequencer states.
// No dependencies; used by the block's RTL files except swr_ram.
`timescale 1ns / 1ps
`default_nettype none

package swr_pkg;

  localparam int BASE_W  = 16;  // base_value register
  localparam int SPAN_W  = 8;   // span register
  localparam int CNT_W   = 9;   // draw_count register and pick index
  localparam int REM_W   = 9;   // remaining count, 1..256
  localparam int OFF_W   = 8;   // stored offset
  localparam int DRAWN_W = 17;  // drawn_value
  localparam int STEP_W  = 4;   // scaler step counter, holds REM_W
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_SPAN  = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_MOD,
    S_RDL,
    S_RDR,
    S_WR,
    S_OUT
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/swr_chan_if.sv */
// Valid/ready channel interfaces for the sampler input and result streams.
// Depends on swr_pkg for the result widths.
`timescale 1ns / 1ps
`default_nettype none

interface swr_in_if #(
  parameter int FRACTION_BITS = 53
) ();
  logic                     valid;
  logic                     ready;
  logic [FRACTION_BITS-1:0] random_fraction;

  modport source (output valid, output random_fraction, input ready);
  modport sink (input valid, input random_fraction, output ready);
endinterface

interface swr_out_if ();
  logic                                valid;
  logic                                ready;
  logic signed [swr_pkg::DRAWN_W-1:0]  drawn_value;
  logic                                last_of_run;

  modport source (output valid, output drawn_value, output last_of_run, input ready);
  modport sink (input valid, input drawn_value, input last_of_run, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sample_without_replacement_unit.sv */
// Distinct-value sampler (partial Fisher-Yates draw without replacement) - top level.
// Each transfer on in_chan carries one FRACTION_BITS-bit uniform fraction; the block
// answers with one transfer on out_chan: base_value plus a not-yet-drawn offset from
// 0..span, and last_of_run on the final pick of a run. A run is
// min(max(draw_count,1), span+1) picks; after it the table starts fresh. Slot choice
// is exact: r = (fraction * remaining) >> FRACTION_BITS. From the accepting edge an item
// passes through the shift-add scaler (nine steps, one bit of the 9-bit remaining count
// each, then a hand-over of the product), an index fold that subtracts TABLE_DEPTH until
// both indexes lie in the table (nothing to subtract when TABLE_DEPTH >= 256), three
// steps on the single-port offset RAM (read last entry, read picked entry, write back)
// and a load of the result register, which raises out_chan.valid. The load waits while
// an earlier result still sits in the output register and is not taken in that cycle.
// in_chan is ready only while the sequencer is idle, again on the cycle after the
// load, so a new item is not taken before the last one is loaded; a finished result
// may wait in the output register while the next item is taken. Written marks sit
// in flip-flops, so no clearing pass follows reset. Configuration goes through an
// APB-style port: base_value at 0x0, span at 0x4, draw_count at 0x8; pready is
// tied high. Write registers only while no item is in flight.
// Depends on swr_pkg, swr_chan_if, swr_scaler and swr_ram.
`timescale 1ns / 1ps
`default_nettype none

module sample_without_replacement_unit #(
  parameter int TABLE_DEPTH   = 256,
  parameter int FRACTION_BITS = 53
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  swr_in_if.sink                             in_chan,
  swr_out_if.source                          out_chan,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [swr_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [swr_pkg::PDATA_W-1:0]   pwdata,
  output logic      [swr_pkg::PDATA_W-1:0]   prdata,
  output logic                               pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // compare width: holds TABLE_DEPTH and any 9-bit index
  localparam int CW = (AW + 1 > swr_pkg::REM_W) ? AW + 1 : swr_pkg::REM_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  // ---- configuration registers ----
  logic [swr_pkg::BASE_W-1:0] base_r, base_nxt;
  logic [swr_pkg::SPAN_W-1:0] span_r, span_nxt;
  logic [swr_pkg::CNT_W-1:0]  count_r, count_nxt;
  logic                       cfg_wr;
  swr_pkg::reg_idx_t          reg_sel;

  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = swr_pkg::reg_idx_t'(paddr[3:2]);
  assign pready  = 1'b1;

  always_comb begin
    base_nxt  = base_r;
    span_nxt  = span_r;
    count_nxt = count_r;
    if (cfg_wr) begin
      case (reg_sel)
        swr_pkg::REG_BASE:  base_nxt  = pwdata[swr_pkg::BASE_W-1:0];
        swr_pkg::REG_SPAN:  span_nxt  = pwdata[swr_pkg::SPAN_W-1:0];
        swr_pkg::REG_COUNT: count_nxt = pwdata[swr_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      swr_pkg::REG_BASE:  prdata = swr_pkg::PDATA_W'(base_r);
      swr_pkg::REG_SPAN:  prdata = swr_pkg::PDATA_W'(span_r);
      swr_pkg::REG_COUNT: prdata = swr_pkg::PDATA_W'(count_r);
      default:            prdata = '0;
    endcase
  end

  // ---- run bookkeeping ----
  logic [swr_pkg::CNT_W-1:0] run_n, run_size, run_limit;
  logic                      run_done;
  logic [swr_pkg::REM_W-1:0] rem_load;
  logic [swr_pkg::CNT_W-1:0] pick_r, pick_nxt;

  // zero draw count behaves as one; count above span+1 is cut to span+1
  assign run_n     = (count_r == '0) ? swr_pkg::CNT_W'(1) : count_r;
  assign run_size  = swr_pkg::CNT_W'(span_r) + 1'b1;
  assign run_limit = (run_n < run_size) ? run_n : run_size;
  assign run_done  = (pick_r >= run_limit);
  // a config change may leave pick_r past the new limit: start over first
  assign rem_load  = run_size - (run_done ? '0 : pick_r);

  // ---- sequencer ----
  swr_pkg::state_t           state_r, state_nxt;
  logic [swr_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [swr_pkg::REM_W-1:0] ridx_r, ridx_nxt;   // picked slot
  logic [swr_pkg::REM_W-1:0] lidx_r, lidx_nxt;   // last live slot
  logic [swr_pkg::OFF_W-1:0] lval_r, lval_nxt;
  logic [swr_pkg::OFF_W-1:0] val_r, val_nxt;
  logic [TABLE_DEPTH-1:0]    mark_r, mark_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [swr_pkg::DRAWN_W-1:0] out_drawn_r, out_drawn_nxt;
  logic                      out_last_r, out_last_nxt;

  logic                      in_xfer;
  logic                      ridx_big, lidx_big;
  logic [CW-1:0]             ridx_ext, lidx_ext;
  logic [AW-1:0]             raddr, laddr;
  logic                      ram_we;
  logic [AW-1:0]             ram_addr;
  logic [swr_pkg::OFF_W-1:0] ram_rdata;
  logic                      scl_start, scl_done;
  logic [swr_pkg::REM_W-1:0] scl_res;
  logic signed [swr_pkg::DRAWN_W-1:0] drawn_sum;

  assign in_chan.ready = (state_r == swr_pkg::S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign scl_start     = in_xfer;

  assign ridx_ext = CW'(ridx_r);
  assign lidx_ext = CW'(lidx_r);
  assign ridx_big = (ridx_ext >= DEPTH_C);
  assign lidx_big = (lidx_ext >= DEPTH_C);
  assign raddr    = ridx_ext[AW-1:0];
  assign laddr    = lidx_ext[AW-1:0];
  assign ram_addr = (state_r == swr_pkg::S_RDL) ? laddr : raddr;

  assign drawn_sum = swr_pkg::DRAWN_W'($signed(base_r)) +
                     $signed(swr_pkg::DRAWN_W'(val_r));

  always_comb begin
    state_nxt     = state_r;
    pick_nxt      = pick_r;
    mark_nxt      = mark_r;
    rem_nxt       = rem_r;
    ridx_nxt      = ridx_r;
    lidx_nxt      = lidx_r;
    lval_nxt      = lval_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_drawn_nxt = out_drawn_r;
    out_last_nxt  = out_last_r;
    ram_we        = 1'b0;
    case (state_r)
      swr_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (run_done) begin
            pick_nxt = '0;
            mark_nxt = '0;
          end
          rem_nxt   = rem_load;
          state_nxt = swr_pkg::S_MUL;
        end
      end
      swr_pkg::S_MUL: begin
        if (scl_done) begin
          ridx_nxt  = (scl_res >= rem_r) ? rem_r - 1'b1 : scl_res;
          lidx_nxt  = rem_r - 1'b1;
          state_nxt = swr_pkg::S_MOD;
        end
      end
      swr_pkg::S_MOD: begin
        // fold indexes into the table, one subtract per cycle
        if (ridx_big) ridx_nxt = ridx_r - DEPTH_C[swr_pkg::REM_W-1:0];
        if (lidx_big) lidx_nxt = lidx_r - DEPTH_C[swr_pkg::REM_W-1:0];
        if (!ridx_big && !lidx_big) state_nxt = swr_pkg::S_RDL;
      end
      swr_pkg::S_RDL: begin
        state_nxt = swr_pkg::S_RDR;
      end
      swr_pkg::S_RDR: begin
        // unwritten entry reads as its own index
        lval_nxt  = mark_r[laddr] ? ram_rdata : lidx_r[swr_pkg::OFF_W-1:0];
        state_nxt = swr_pkg::S_WR;
      end
      swr_pkg::S_WR: begin
        val_nxt         = mark_r[raddr] ? ram_rdata : ridx_r[swr_pkg::OFF_W-1:0];
        ram_we          = 1'b1;
        mark_nxt[raddr] = 1'b1;
        pick_nxt        = pick_r + 1'b1;
        state_nxt       = swr_pkg::S_OUT;
      end
      swr_pkg::S_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_drawn_nxt = drawn_sum;
          out_last_nxt  = run_done;
          if (run_done) begin
            pick_nxt = '0;
            mark_nxt = '0;
          end
          state_nxt = swr_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swr_pkg::S_IDLE;
      pick_r      <= '0;
      mark_r      <= '0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
      span_r      <= swr_pkg::SPAN_W'(255);
      count_r     <= swr_pkg::CNT_W'(1);
    end else begin
      state_r     <= state_nxt;
      pick_r      <= pick_nxt;
      mark_r      <= mark_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      span_r      <= span_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    ridx_r      <= ridx_nxt;
    lidx_r      <= lidx_nxt;
    lval_r      <= lval_nxt;
    val_r       <= val_nxt;
    out_drawn_r <= out_drawn_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.drawn_value = out_drawn_r;
  assign out_chan.last_of_run = out_last_r;

  // ---- shared scaler and offset table ----
  swr_scaler #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_scaler (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scl_start),
    .frac   (in_chan.random_fraction),
    .mult   (rem_load),
    .done   (scl_done),
    .result (scl_res)
  );

  swr_ram #(
    .WIDTH (swr_pkg::OFF_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (lval_r),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/swr_ram.sv */
// Generic single-port RAM, write or registered read each cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                          wdata,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end else begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/swr_scaler.sv */
// Shift-add scaler: result = (frac * mult) >> FRACTION_BITS, one multiplier bit a cycle.
// Depends on swr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swr_scaler #(
  parameter int FRACTION_BITS = 53
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [FRACTION_BITS-1:0]    frac,
  input  wire logic [swr_pkg::REM_W-1:0]   mult,
  output logic                             done,
  output logic      [swr_pkg::REM_W-1:0]   result
);

  localparam int PW = FRACTION_BITS + swr_pkg::REM_W;

  logic [PW-1:0]                 acc_r, acc_nxt;
  logic [FRACTION_BITS-1:0]      frac_r, frac_nxt;
  logic [swr_pkg::REM_W-1:0]     mb_r, mb_nxt;
  logic [swr_pkg::STEP_W-1:0]    cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [PW-1:0]                 addend;

  // MSB-first: acc = 2*acc + bit*frac
  assign addend = mb_r[swr_pkg::REM_W-1] ? PW'(frac_r) : '0;

  always_comb begin
    acc_nxt  = acc_r;
    frac_nxt = frac_r;
    mb_nxt   = mb_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      frac_nxt = frac;
      mb_nxt   = mult;
      cnt_nxt  = swr_pkg::STEP_W'(swr_pkg::REM_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[PW-2:0], 1'b0} + addend;
      mb_nxt  = {mb_r[swr_pkg::REM_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == swr_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    frac_r <= frac_nxt;
    mb_r   <= mb_nxt;
  end

  assign done   = done_r;
  assign result = acc_r[PW-1 -: swr_pkg::REM_W];

endmodule

`default_nettype wire

/* hw/rtl/swr_checker.sv */
// Port-level checks for the distinct-value sampler, bound to the top level.
// Depends on swr_pkg and sample_without_replacement_unit_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "sample_without_replacement_unit_assert.svh"

module swr_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic signed [swr_pkg::DRAWN_W-1:0] drawn_value,
  input wire logic                               pready
);

  // block goes busy after taking an item
  `SWR_ASSERT_CLK(a_busy_after_take, (in_valid && in_ready) |=> !in_ready, "ready after take")
  // a new result only comes out of an item in flight
  `SWR_ASSERT_CLK(a_result_from_item, $rose(out_valid) |-> $past(!in_ready), "stray result")
  `SWR_ASSERT_CLK(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(drawn_value)), "result dropped")
  // base plus offset stays inside base range plus 255
  `SWR_ASSERT_CLK(a_drawn_range, out_valid |-> (drawn_value <= 17'sd33022), "drawn value out of range")
  `SWR_ASSERT_ANY(a_pready_high, pready, "pready low")

endmodule

bind sample_without_replacement_unit swr_checker u_swr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .drawn_value (out_chan.drawn_value),
  .pready      (pready)
);

`default_nettype wire
